### hdl/compressor_thermostat_controller_core_defines.svh
// Assertion macros for the compressor thermostat controller.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef COMPRESSOR_THERMOSTAT_CONTROLLER_CORE_DEFINES_SVH
`define COMPRESSOR_THERMOSTAT_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check prop on every clock edge outside reset
`define CTC_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("ctc check failed");
// check prop on every clock edge, reset included
`define CTC_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("ctc check failed");
`else
`define CTC_ASSERT(lbl, clk_s, rst_s, prop)
`define CTC_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

### hdl/ctc_pkg.sv
// Shared types and constants for the compressor thermostat controller.
// No dependencies.
`default_nettype none

package ctc_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_BOOST = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    LAMP_OFF   = 2'd0,
    LAMP_ON    = 2'd1,
    LAMP_BLINK = 2'd2
  } lamp_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_DEGREES_OVER  = 3'd0,
    REG_DEGREES_UNDER = 3'd1,
    REG_MIN_RUN       = 3'd2,
    REG_MIN_STOP      = 3'd3,
    REG_MAX_RUN       = 3'd4,
    REG_BOOST_TARGET  = 3'd5,
    REG_HIGH_ALARM    = 3'd6,
    REG_LOW_ALARM     = 3'd7
  } reg_index_t;

endpackage

`default_nettype wire

### hdl/ctc_if.sv
// Request and report channels of the compressor thermostat controller.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ctc_request_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [7:0] temperature;
  logic signed [7:0] setpoint;
  logic              setpoint_off;
  logic              probe_fault;
  logic              reading_ready;

  modport source (output valid, command, temperature, setpoint, setpoint_off,
                  probe_fault, reading_ready, input ready);
  modport sink (input valid, command, temperature, setpoint, setpoint_off,
                probe_fault, reading_ready, output ready);
endinterface

interface ctc_report_if;
  logic        valid;
  logic        ready;
  logic        motor_on;
  logic [1:0]  indicator;
  logic        boost_on;
  logic        temp_alarm;
  logic [15:0] run_minutes;
  logic [15:0] stopped_minutes;

  modport source (output valid, motor_on, indicator, boost_on, temp_alarm,
                  run_minutes, stopped_minutes, input ready);
  modport sink (input valid, motor_on, indicator, boost_on, temp_alarm,
                run_minutes, stopped_minutes, output ready);
endinterface

`default_nettype wire

### hdl/compressor_thermostat_controller_core.sv
// Top level of the compressor thermostat controller.
// Uses ctc_pkg, ctc_request_if, ctc_report_if and the assertion macro header.
`default_nettype none
`include "compressor_thermostat_controller_core_defines.svh"

// One compressor controller: takes minute ticks, boost toggles and evaluate
// items and returns one report item per request item. Each accepted item is
// decided by one pass of compare logic and lands in the report register on
// the next clock edge, so the block takes one item per cycle unless stalled;
// the report register alone sets the rate, and a new item is
// taken whenever that register is empty or is being read in the same cycle.
// Configuration writes take effect at the edge they are written.
module compressor_thermostat_controller_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ctc_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [ctc_pkg::CfgDataW-1:0]   cfg_data,
  ctc_request_if.sink                         request,
  ctc_report_if.source                        report
);

  // configuration
  logic [4:0]        degrees_over;
  logic [4:0]        degrees_under;
  logic [15:0]       min_run_minutes;
  logic [15:0]       min_stop_minutes;
  logic [14:0]       max_run_minutes;
  logic signed [7:0] boost_target_temp;
  logic signed [7:0] high_alarm_temp;
  logic signed [7:0] low_alarm_temp;

  // controller state
  logic                         motor_running, motor_running_next;
  logic [ctc_pkg::CountW-1:0]   run_count, run_count_next;
  logic [ctc_pkg::CountW-1:0]   stop_count, stop_count_next;
  logic                         boost_mode, boost_mode_next;
  ctc_pkg::lamp_t               lamp_state, lamp_state_next;
  logic                         alarm_flag, alarm_flag_next;

  logic report_valid;
  logic accept;

  assign request.ready = !report_valid || report.ready;
  assign accept        = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      degrees_over      <= 5'd2;
      degrees_under     <= 5'd2;
      min_run_minutes   <= 16'd5;
      min_stop_minutes  <= 16'd5;
      max_run_minutes   <= 15'd120;
      boost_target_temp <= 8'sd0;
      high_alarm_temp   <= 8'sd10;
      low_alarm_temp    <= -8'sd2;
    end else if (cfg_we) begin
      unique case (ctc_pkg::reg_index_t'(cfg_index))
        ctc_pkg::REG_DEGREES_OVER:  degrees_over      <= cfg_data[4:0];
        ctc_pkg::REG_DEGREES_UNDER: degrees_under     <= cfg_data[4:0];
        ctc_pkg::REG_MIN_RUN:       min_run_minutes   <= cfg_data[15:0];
        ctc_pkg::REG_MIN_STOP:      min_stop_minutes  <= cfg_data[15:0];
        ctc_pkg::REG_MAX_RUN:       max_run_minutes   <= cfg_data[14:0];
        ctc_pkg::REG_BOOST_TARGET:  boost_target_temp <= $signed(cfg_data[7:0]);
        ctc_pkg::REG_HIGH_ALARM:    high_alarm_temp   <= $signed(cfg_data[7:0]);
        ctc_pkg::REG_LOW_ALARM:     low_alarm_temp    <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // evaluate datapath
  logic              warm, cold, overrun, boost_in_time;
  logic signed [9:0] temp_w, stop_below, start_at;
  logic              run;

  assign temp_w        = 10'(request.temperature);
  assign stop_below    = 10'(request.setpoint) - $signed({5'd0, degrees_under});
  assign start_at      = 10'(request.setpoint) + $signed({5'd0, degrees_over});
  assign warm          = request.temperature >= high_alarm_temp;
  assign cold          = request.temperature <= low_alarm_temp;
  assign overrun       = run_count >= {1'b0, max_run_minutes};
  assign boost_in_time = {1'b0, run_count} <= {1'b0, max_run_minutes, 1'b0};

  always_comb begin
    motor_running_next = motor_running;
    run_count_next     = run_count;
    stop_count_next    = stop_count;
    boost_mode_next    = boost_mode;
    lamp_state_next    = lamp_state;
    alarm_flag_next    = alarm_flag;
    run                = 1'b0;
    unique case (ctc_pkg::cmd_t'(request.command))
      ctc_pkg::CMD_TICK: begin
        if (motor_running) begin
          if (run_count != ctc_pkg::CountMax) run_count_next = run_count + 1'b1;
          stop_count_next = '0;
        end else begin
          if (stop_count != ctc_pkg::CountMax) stop_count_next = stop_count + 1'b1;
          run_count_next = '0;
        end
      end
      ctc_pkg::CMD_EVAL: begin
        if (request.reading_ready) begin
          alarm_flag_next = warm || cold;
          priority if (request.setpoint_off) begin
            run = 1'b0;
          end else if (overrun || request.probe_fault) begin
            run             = 1'b0;
            lamp_state_next = ctc_pkg::LAMP_BLINK;
          end else begin
            run = motor_running ? (temp_w > stop_below) : (temp_w >= start_at);
            if (warm) run = 1'b1;
          end
          if (motor_running && !run && run_count < min_run_minutes) run = 1'b1;
          if (!motor_running && run && stop_count < min_stop_minutes) run = 1'b0;
          if (!run && boost_mode) begin
            if (request.temperature > boost_target_temp && boost_in_time) run = 1'b1;
            else boost_mode_next = 1'b0;
          end
          if (run) begin
            lamp_state_next = boost_mode_next ? ctc_pkg::LAMP_BLINK : ctc_pkg::LAMP_ON;
          end
          if (run && !motor_running) begin
            motor_running_next = 1'b1;
            lamp_state_next    = ctc_pkg::LAMP_ON;
          end else if (!run && motor_running) begin
            motor_running_next = 1'b0;
            lamp_state_next    = ctc_pkg::LAMP_OFF;
            stop_count_next    = '0;
          end
        end
      end
      ctc_pkg::CMD_BOOST: boost_mode_next = !boost_mode;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_running <= 1'b0;
      run_count     <= '0;
      stop_count    <= ctc_pkg::CountMax;
      boost_mode    <= 1'b0;
      lamp_state    <= ctc_pkg::LAMP_OFF;
      alarm_flag    <= 1'b0;
    end else if (accept) begin
      motor_running <= motor_running_next;
      run_count     <= run_count_next;
      stop_count    <= stop_count_next;
      boost_mode    <= boost_mode_next;
      lamp_state    <= lamp_state_next;
      alarm_flag    <= alarm_flag_next;
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (accept) begin
      report_valid <= 1'b1;
    end else if (report.ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      report.motor_on        <= motor_running_next;
      report.indicator       <= lamp_state_next;
      report.boost_on        <= boost_mode_next;
      report.temp_alarm      <= alarm_flag_next;
      report.run_minutes     <= run_count_next;
      report.stopped_minutes <= stop_count_next;
    end
  end

  assign report.valid = report_valid;

  `CTC_ASSERT(a_accept_reports, clk, rst, accept |=> report_valid)
  `CTC_ASSERT(a_stop_clears_count, clk, rst, $fell(motor_running) |-> stop_count == '0)
  `CTC_ASSERT(a_start_lamp_on, clk, rst, $rose(motor_running) |-> lamp_state == ctc_pkg::LAMP_ON)
  `CTC_ASSERT(a_state_holds_idle, clk, rst,
    !accept |=> ($stable(motor_running) && $stable(run_count) && $stable(boost_mode)))

endmodule

`default_nettype wire
